>>> src/sbo_pkg.sv
// Package for the stable bucket-order scatter block.
// Sizes, operation and status codes, and request/result/command types.
// No dependencies.
package sbo_pkg;

	localparam int MAX_LEVELS   = 16;
	localparam int MAX_ELEMENTS = 65536;

	localparam int LVL_W    = $clog2(MAX_LEVELS);
	localparam int LOADED_W = $clog2(MAX_LEVELS + 1);
	localparam int CNT_W    = $clog2(MAX_ELEMENTS + 1);

	// command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_PLACE = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NOT_LOADED = 2'd1;
	localparam logic [1:0] ST_FULL       = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [16:0] level_count;
		logic [15:0] element_index;
		logic [3:0]  element_level;
	} request_t;

	typedef struct packed {
		logic [15:0] slot;
		logic [15:0] placed_index;
		logic [1:0]  status;
	} result_t;

	typedef enum logic [1:0] {
		CMD_CLEAR,
		CMD_LOAD,
		CMD_PLACE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [16:0] count;
		logic [15:0] index;
		logic [3:0]  level;
	} cmd_t;

	typedef struct packed {
		logic near_full;
		logic empty;
	} q_stat_t;

endpackage

>>> src/sbo_front.sv
// Front end: takes requests, decodes the operation, drops the unused code and
// hands commands to the queue. Depends on sbo_pkg.
module sbo_front import sbo_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  request_t request,
	output logic     push,
	output cmd_t     push_cmd
);

	logic      vld_s1;
	cmd_t      cmd_s1;
	logic      keep;
	cmd_kind_t kind;

	always_comb begin
		keep = 1'b1;
		kind = CMD_CLEAR;
		unique case (request.operation)
			OP_CLEAR: kind = CMD_CLEAR;
			OP_LOAD:  kind = CMD_LOAD;
			OP_PLACE: kind = CMD_PLACE;
			default:  keep = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.kind  <= kind;
			cmd_s1.count <= request.level_count;
			cmd_s1.index <= request.element_index;
			cmd_s1.level <= request.element_level;
		end
	end

	assign push     = vld_s1;
	assign push_cmd = cmd_s1;

endmodule

>>> src/sbo_queue.sv
// Short command FIFO decoupling front and back.
// Depends on sbo_pkg.
module sbo_queue import sbo_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    head,
	output q_stat_t stat
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_cmd;
	end

	assign head           = mem_q[rd_q];
	assign stat.empty     = (cnt_q == '0);
	// one command may still sit in the front stage
	assign stat.near_full = (cnt_q >= QCNT_W'(QDEPTH - 1));

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == QCNT_W'(QDEPTH)) |-> (!push || pop))
		else $error("command queue overflow");

endmodule

>>> src/sbo_back.sv
// Back end: runs clear/load/place against the level tables, one command per
// cycle, and registers the result. Depends on sbo_pkg.
module sbo_back import sbo_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_stat_t stat,
	input  cmd_t    head,
	output logic    pop,
	output logic    result_valid,
	output result_t result
);

	logic [CNT_W-1:0]    cursor_q [MAX_LEVELS];
	logic [CNT_W-1:0]    remain_q [MAX_LEVELS];
	logic [CNT_W-1:0]    total_q;
	logic [LOADED_W-1:0] loaded_q;

	logic [LVL_W-1:0] lvl;
	logic [LVL_W-1:0] load_idx;
	logic [CNT_W-1:0] cur;
	logic [CNT_W-1:0] rem;
	logic [CNT_W-1:0] room;
	logic [CNT_W-1:0] clip;
	logic             lvl_loaded;
	logic             tbl_full;
	logic             do_load;
	logic             do_place;
	logic [1:0]       status;

	always_comb begin
		pop        = !stat.empty;
		lvl        = head.level[LVL_W-1:0];
		load_idx   = loaded_q[LVL_W-1:0];
		cur        = cursor_q[lvl];
		rem        = remain_q[lvl];
		lvl_loaded = (LOADED_W'(head.level) < loaded_q);
		tbl_full   = (loaded_q == LOADED_W'(MAX_LEVELS));
		room       = CNT_W'(MAX_ELEMENTS) - total_q;
		clip       = (head.count > room) ? room : head.count;
		do_load    = pop && (head.kind == CMD_LOAD) && !tbl_full;
		status     = ST_OK;
		if (!lvl_loaded)     status = ST_NOT_LOADED;
		else if (rem == '0)  status = ST_FULL;
		do_place   = pop && (head.kind == CMD_PLACE) && (status == ST_OK);
	end

	// level tables: no reset, only read below loaded_q
	always_ff @(posedge clk) begin
		if (do_load) begin
			cursor_q[load_idx] <= total_q;
			remain_q[load_idx] <= clip;
		end else if (do_place) begin
			cursor_q[lvl] <= cur + 1'b1;
			remain_q[lvl] <= rem - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q      <= '0;
			loaded_q     <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= pop && (head.kind == CMD_PLACE);
			if (pop && head.kind == CMD_CLEAR) begin
				total_q  <= '0;
				loaded_q <= '0;
			end else if (do_load) begin
				total_q  <= total_q + clip;
				loaded_q <= loaded_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.kind == CMD_PLACE) begin
			result.slot         <= (status == ST_OK) ? cur[15:0] : 16'd0;
			result.placed_index <= head.index;
			result.status       <= status;
		end
	end

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(MAX_ELEMENTS))
		else $error("running total beyond element limit");

	a_loaded_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= LOADED_W'(MAX_LEVELS))
		else $error("too many levels loaded");

	a_result_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(pop))
		else $error("result without a dequeued command");

endmodule

>>> src/stable_bucket_order_by_level.sv
// Stable counting-sort scatter, top level.
// Place path: front stage register, command queue, then the back end's result register.
// Throughput: one request per cycle unless busy; the back end pops one command per cycle.
// busy rises only when the four-entry command queue nears full; results cannot be stalled.
// Reset clears the queue, running total and loaded-level count; level tables are not cleared.
// Depends on sbo_pkg, sbo_front, sbo_queue, sbo_back.
module stable_bucket_order_by_level import sbo_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  request_t request,
	output logic     result_valid,
	output result_t  result
);

	logic    accept;
	logic    push;
	logic    pop;
	cmd_t    push_cmd;
	cmd_t    head;
	q_stat_t stat;

	// a request is taken when start is high and the queue has room
	assign busy   = stat.near_full;
	assign accept = start && !busy;

	// front: decode opcode, drop the unused one
	sbo_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.request  (request),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// queue keeps commands in arrival order
	sbo_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	// back: table read-modify-write for place, append for load
	sbo_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.stat         (stat),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
